### rtl/rsfr_pkg.sv
// Shared types and constants for the bus-slave frame receiver.
// Used by every module of the block; depends on nothing.
package rsfr_pkg;

   localparam int MAX_PAYLOAD_DEF = 255;
   localparam int CMD_DEPTH = 4;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
   localparam logic [8:0] BROADCAST_SKIP = 9'd5;
   localparam logic [1:0] DRIVER_HOLD = 2'd2;

   localparam logic CSR_STORED_ADDRESS = 1'b0;
   localparam logic CSR_HARDWARE_TYPE = 1'b1;

   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_DELIVERED = 3'd1;
   localparam logic [2:0] KIND_ANSWER = 3'd2;
   localparam logic [2:0] KIND_TRANSMIT = 3'd3;
   localparam logic [2:0] KIND_ADDRESS = 3'd4;
   localparam logic [2:0] KIND_TICK = 3'd5;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_ANSWER,
      CMD_PAYLOAD,
      CMD_ASSIGN
   } cmd_op_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_value;
      logic [8:0]  byte_index;
      logic [15:0] message_id;
      logic [7:0]  message_length;
      logic [15:0] address_value;
      logic        driver_enable;
      logic        last;
   } rsp_type;

   typedef struct packed {
      cmd_op_type  op;
      logic        fin;
      logic        drv;
      logic [7:0]  value;
      logic [7:0]  prev;
      logic [8:0]  index;
      logic [15:0] ident;
      logic [7:0]  len;
      logic [15:0] addr;
      logic [15:0] hw;
   } cmd_type;

endpackage

### rtl/rsfr_front.sv
// Front end: frame parser, node address, driver timer and configuration registers.
// Turns each accepted word into at most one command. Depends on rsfr_pkg.
module rsfr_front #(
   parameter int MaxPayload = rsfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rsfr_pkg::req_type in_item,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   output logic              cmd_push,
   output rsfr_pkg::cmd_type cmd_data
);

   localparam logic [7:0] MaxLen = 8'(MaxPayload);

   typedef enum logic [2:0] {
      ST_START,
      ST_ADDR,
      ST_NEWADDR,
      ST_INFO,
      ST_DATA,
      ST_SKIP
   } state_type;

   state_type   state_ff, state_in;
   logic [8:0]  count_ff, count_in;
   logic [8:0]  skip_ff, skip_in;
   logic [15:0] frame_ff, frame_in;
   logic [15:0] assigned_ff, assigned_in;
   logic [15:0] ident_ff, ident_in;
   logic        write_ff, write_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  prev_ff, prev_in;
   logic [15:0] node_ff, node_in;
   logic [15:0] hw_ff, hw_in;
   logic        drv_ff, drv_in;
   logic [1:0]  hold_ff, hold_in;
   logic [8:0]  count_inc;
   logic [7:0]  b;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      skip_in = skip_ff;
      frame_in = frame_ff;
      assigned_in = assigned_ff;
      ident_in = ident_ff;
      write_in = write_ff;
      len_in = len_ff;
      prev_in = prev_ff;
      node_in = node_ff;
      hw_in = hw_ff;
      drv_in = drv_ff;
      hold_in = hold_ff;
      b = in_item.rx_byte;
      count_inc = count_ff + 9'd1;
      cmd_push = 1'b0;
      cmd_data = '0;
      cmd_data.op = rsfr_pkg::CMD_TICK;
      cmd_data.value = b;
      cmd_data.prev = prev_ff;
      cmd_data.index = count_ff;
      cmd_data.ident = ident_ff;
      cmd_data.len = len_ff;
      cmd_data.hw = hw_ff;
      cmd_data.drv = drv_ff;

      if (csr_write) begin
         if (csr_index == rsfr_pkg::CSR_STORED_ADDRESS) begin
            node_in = csr_wdata;
         end else begin
            hw_in = csr_wdata;
         end
      end

      if (in_valid && in_item.req_type) begin
         if (hold_ff != 2'd0) begin
            hold_in = hold_ff - 2'd1;
            if (hold_ff == 2'd1) begin
               drv_in = 1'b0;
            end
         end
         cmd_push = 1'b1;
         cmd_data.op = rsfr_pkg::CMD_TICK;
         cmd_data.drv = drv_in;
      end else if (in_valid && !in_item.rx_error) begin
         prev_in = b;
         unique case (state_ff)
            ST_ADDR: begin
               if (count_ff == 9'd0) begin
                  frame_in = {b, 8'd0};
                  count_in = 9'd1;
               end else begin
                  frame_in = {frame_ff[15:8], b};
                  count_in = 9'd0;
                  if (frame_in == rsfr_pkg::BROADCAST_ADDR) begin
                     if (node_ff == rsfr_pkg::BROADCAST_ADDR) begin
                        state_in = ST_NEWADDR;
                     end else begin
                        state_in = ST_SKIP;
                        skip_in = rsfr_pkg::BROADCAST_SKIP;
                     end
                  end else begin
                     state_in = ST_INFO;
                     ident_in = 16'd0;
                  end
               end
            end
            ST_INFO: begin
               count_in = count_inc;
               if (count_ff == 9'd0) begin
                  ident_in = {b, 8'd0};
               end else if (count_ff == 9'd1) begin
                  ident_in = {ident_ff[15:8], b};
               end else if (count_ff == 9'd2) begin
                  write_in = (b == 8'd1);
               end else begin
                  len_in = b;
               end
               if (count_inc > 9'd3) begin
                  count_in = 9'd0;
                  if (frame_ff != node_ff) begin
                     skip_in = {1'b0, len_in};
                     state_in = ST_SKIP;
                  end else if (write_in) begin
                     if (len_in > MaxLen) begin
                        skip_in = {1'b0, len_in} + 9'd1;
                        state_in = ST_SKIP;
                     end else begin
                        state_in = ST_DATA;
                     end
                  end else begin
                     cmd_push = 1'b1;
                     cmd_data.op = rsfr_pkg::CMD_ANSWER;
                     cmd_data.ident = ident_in;
                     state_in = ST_START;
                  end
               end
            end
            ST_DATA: begin
               cmd_push = 1'b1;
               cmd_data.op = rsfr_pkg::CMD_PAYLOAD;
               count_in = count_inc;
               if ({1'b0, count_inc} >= ({2'b00, len_ff} + 10'd2)) begin
                  cmd_data.fin = 1'b1;
                  drv_in = 1'b1;
                  hold_in = rsfr_pkg::DRIVER_HOLD;
                  count_in = 9'd0;
                  state_in = ST_START;
               end
            end
            ST_NEWADDR: begin
               if (count_ff == 9'd0) begin
                  assigned_in = {b, 8'd0};
                  count_in = 9'd1;
               end else begin
                  assigned_in = {assigned_ff[15:8], b};
                  count_in = 9'd0;
                  node_in = assigned_in;
                  cmd_push = 1'b1;
                  cmd_data.op = rsfr_pkg::CMD_ASSIGN;
                  cmd_data.addr = assigned_in;
                  drv_in = 1'b1;
                  hold_in = rsfr_pkg::DRIVER_HOLD;
                  state_in = ST_START;
               end
            end
            ST_SKIP: begin
               if (skip_ff == 9'd0) begin
                  state_in = ST_START;
               end
               skip_in = skip_ff - 9'd1;
            end
            default: begin
               if (b == rsfr_pkg::START_BYTE) begin
                  state_in = ST_ADDR;
                  count_in = 9'd0;
               end else begin
                  state_in = ST_START;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= '0;
         skip_ff <= '0;
         frame_ff <= '0;
         assigned_ff <= '0;
         ident_ff <= '0;
         write_ff <= 1'b0;
         len_ff <= '0;
         prev_ff <= '0;
         node_ff <= rsfr_pkg::BROADCAST_ADDR;
         hw_ff <= '0;
         drv_ff <= 1'b0;
         hold_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         skip_ff <= skip_in;
         frame_ff <= frame_in;
         assigned_ff <= assigned_in;
         ident_ff <= ident_in;
         write_ff <= write_in;
         len_ff <= len_in;
         prev_ff <= prev_in;
         node_ff <= node_in;
         hw_ff <= hw_in;
         drv_ff <= drv_in;
         hold_ff <= hold_in;
      end
   end

endmodule

### rtl/rsfr_queue.sv
// Short command queue between the parser and the result serialiser.
// Depends on rsfr_pkg for the command type.
module rsfr_queue #(
   parameter int Depth = rsfr_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsfr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rsfr_pkg::cmd_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   rsfr_pkg::cmd_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == DepthCnt);
   assign valid = (count_ff != '0);
   assign head = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/rsfr_back.sv
// Back end: expands each command into its result words, one per cycle while rsp_pop keeps
// taking them, through a registered output stage. Depends on rsfr_pkg.
module rsfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  rsfr_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsfr_pkg::rsp_type rsp_data
);

   rsfr_pkg::cmd_type cmd_ff, cmd_in;
   rsfr_pkg::rsp_type out_ff, out_in;
   rsfr_pkg::rsp_type res;
   logic       busy_ff, busy_in;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] step_ff, step_in;
   logic       advance, done;

   always_comb begin
      res = '0;
      res.driver_enable = 1'b1;
      res.kind = rsfr_pkg::KIND_TRANSMIT;
      case (cmd_ff.op)
         rsfr_pkg::CMD_TICK: begin
            res.kind = rsfr_pkg::KIND_TICK;
            res.driver_enable = cmd_ff.drv;
            res.last = 1'b1;
         end
         rsfr_pkg::CMD_ANSWER: begin
            res.kind = rsfr_pkg::KIND_ANSWER;
            res.message_id = cmd_ff.ident;
            res.driver_enable = cmd_ff.drv;
            res.last = 1'b1;
         end
         rsfr_pkg::CMD_PAYLOAD: begin
            case (step_ff)
               3'd0: begin
                  res.kind = rsfr_pkg::KIND_PAYLOAD;
                  res.byte_value = cmd_ff.value;
                  res.byte_index = cmd_ff.index;
                  res.driver_enable = cmd_ff.drv;
                  res.last = !cmd_ff.fin;
               end
               3'd1: begin
                  res.kind = rsfr_pkg::KIND_DELIVERED;
                  res.message_id = cmd_ff.ident;
                  res.message_length = cmd_ff.len;
                  res.driver_enable = cmd_ff.drv;
               end
               3'd2: res.byte_value = rsfr_pkg::START_BYTE;
               3'd3: res.byte_value = cmd_ff.prev;
               default: begin
                  res.byte_value = cmd_ff.value;
                  res.last = 1'b1;
               end
            endcase
         end
         default: begin
            case (step_ff)
               3'd0: begin
                  res.kind = rsfr_pkg::KIND_ADDRESS;
                  res.address_value = cmd_ff.addr;
                  res.driver_enable = cmd_ff.drv;
               end
               3'd1: res.byte_value = cmd_ff.addr[15:8];
               3'd2: res.byte_value = cmd_ff.addr[7:0];
               3'd3: res.byte_value = cmd_ff.hw[15:8];
               3'd4: res.byte_value = cmd_ff.hw[7:0];
               3'd5: res.byte_value = 8'd0;
               default: begin
                  res.byte_value = rsfr_pkg::START_BYTE ^ cmd_ff.hw[15:8] ^ cmd_ff.hw[7:0];
                  res.last = 1'b1;
               end
            endcase
         end
      endcase
   end

   assign advance = busy_ff && (!out_valid_ff || rsp_pop);
   assign done = advance && res.last;
   assign cmd_pop = cmd_valid && (!busy_ff || done);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      cmd_in = cmd_ff;
      out_in = out_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_in = res;
         out_valid_in = 1'b1;
         step_in = step_ff + 3'd1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (cmd_pop) begin
         cmd_in = cmd_head;
         busy_in = 1'b1;
         step_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
         step_ff <= step_in;
      end
   end

endmodule

### rtl/rs485_slave_frame_receiver_core.sv
// Top level of the bus-slave frame receiver: parser, command queue and serialiser.
// Depends on rsfr_pkg, rsfr_front, rsfr_queue and rsfr_back.
//
// An input word is taken whenever req_full is low, so words may arrive on consecutive
// cycles; the parser acts on each at once and hands at most one command to a four-entry
// queue. The serialiser turns each command into its result words at one per cycle while
// rsp_pop keeps taking them (one for a tick, an answer request or a payload byte, five for
// the last byte of a message, seven for an address assignment) through a registered output
// stage, so a word yields from none to seven result words, and with an idle serialiser its
// first result passes the queue, the command register and the output register before it
// reaches the result ports. req_full rises when four commands are waiting, either behind
// a stalled consumer or because commands that expand into several words arrive faster
// than they drain. Configuration writes take effect at the next clock edge.
module rs485_slave_frame_receiver_core #(
   parameter int MaxPayload = rsfr_pkg::MAX_PAYLOAD_DEF,
   parameter int CmdDepth = rsfr_pkg::CMD_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rsfr_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsfr_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   logic              accept;
   logic              cmd_push;
   rsfr_pkg::cmd_type cmd_data;
   logic              cmd_valid;
   logic              cmd_pop;
   rsfr_pkg::cmd_type cmd_head;

   assign accept = req_push && !req_full;

   rsfr_front #(
      .MaxPayload(MaxPayload)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_data)
   );

   rsfr_queue #(
      .Depth(CmdDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (req_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   rsfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
